/* rtl/mandelbrot_escape_time_unit_assert.svh */
// assertion macros used by the escape time unit controller
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define MET_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define MET_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MET_ASSERT_NOW(name, ante, cons, msg)
`define MET_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

/* rtl/met_pkg.sv */
// types, constants and helper functions of the escape time unit
package met_pkg;

   // sizes of fields and registers
   localparam int COORD_BITS  = 12;
   localparam int DIM_W       = 13;
   localparam int STEP_W      = 31;
   localparam int COUNT_W     = 8;
   localparam int ADDR_W      = 24;
   localparam int Q_W         = 32;
   localparam int Q_FRAC      = 28;
   localparam int WIDE_W      = 2 * Q_W;
   localparam int SAT_W       = 48;
   localparam int DELTA_W     = DIM_W + 1;
   localparam int PROD_W      = DELTA_W + Q_W;
   localparam int ADDR_FULL_W = COORD_BITS + DIM_W;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = STEP_W;

   localparam logic [COUNT_W-1:0] MAX_ITERATIONS = 8'd255;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_STEP   = 2'd2;

   localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd512;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd512;
   localparam logic [STEP_W-1:0] STEP_RESET   = 31'd2097152;

   // |z|^2 limit of 4 in Q8.56
   localparam logic [WIDE_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

   localparam logic signed [SAT_W-1:0] Q4_MAX = {{(SAT_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] Q4_MIN = {{(SAT_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_LOAD = 6'b000010,
      S_INIT = 6'b000100,
      S_MUL  = 6'b001000,
      S_UPD  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   typedef struct packed {
      logic capture;   // take the pixel coordinates
      logic point;     // form the c products and the address
      logic init;      // saturate c, clear z and the count
      logic square;    // form the three products of z
      logic step;      // z = z*z + c, count up
      logic result;    // load the output register
   } cmd_type;

   typedef struct packed {
      logic at_max;    // count has reached the iteration limit
      logic escaped;   // |z|^2 of the current z is at or above 4
   } status_type;

   // clamp to the Q4.28 range
   function automatic logic signed [Q_W-1:0] sat_q4(input logic signed [SAT_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > Q4_MAX) begin
         r = {1'b0, {(Q_W-1){1'b1}}};
      end else if (v < Q4_MIN) begin
         r = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/met_datapath.sv */
// datapath: config registers, point setup, shared square-and-add unit, result register
module met_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [met_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [met_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [met_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  met_pkg::cmd_type                 cmd,
   output met_pkg::status_type              status,
   output logic [met_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic [met_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [met_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [met_pkg::STEP_W-1:0] step_ff, step_in;

   logic [met_pkg::COORD_BITS-1:0] x_ff, x_in;
   logic [met_pkg::COORD_BITS-1:0] y_ff, y_in;

   logic signed [met_pkg::PROD_W-1:0] pre_re_ff, pre_re_in;
   logic signed [met_pkg::PROD_W-1:0] pre_im_ff, pre_im_in;
   logic [met_pkg::ADDR_W-1:0]        addr_ff, addr_in;

   logic signed [met_pkg::Q_W-1:0] cre_ff, cre_in;
   logic signed [met_pkg::Q_W-1:0] cim_ff, cim_in;
   logic signed [met_pkg::Q_W-1:0] zre_ff, zre_in;
   logic signed [met_pkg::Q_W-1:0] zim_ff, zim_in;
   logic [met_pkg::COUNT_W-1:0]    count_ff, count_in;

   logic signed [met_pkg::WIDE_W-1:0] rr_ff, rr_in;
   logic signed [met_pkg::WIDE_W-1:0] ii_ff, ii_in;
   logic signed [met_pkg::WIDE_W-1:0] ri_ff, ri_in;

   logic [met_pkg::COUNT_W-1:0] count_out_ff, count_out_in;
   logic [met_pkg::ADDR_W-1:0]  addr_out_ff, addr_out_in;

   logic signed [met_pkg::DELTA_W-1:0]  two_x_s, two_y_s, width_s, height_s, dre, dim;
   logic signed [met_pkg::Q_W-1:0]      step_s;
   logic [met_pkg::ADDR_FULL_W-1:0]     addr_full;
   logic signed [met_pkg::SAT_W-1:0]    re_ext, im_ext;
   logic [met_pkg::WIDE_W-1:0]          mag;
   logic signed [met_pkg::WIDE_W-1:0]   diff, shr_re, shr_im;
   logic signed [met_pkg::SAT_W-1:0]    nre, nim;

   // configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      step_in   = step_ff;
      if (csr_wr_en) begin
         case (csr_index)
            met_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata[met_pkg::DIM_W-1:0];
            met_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata[met_pkg::DIM_W-1:0];
            met_pkg::CSR_PIXEL_STEP:   step_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // point setup: c products before halving, and the buffer address
   always_comb begin
      two_x_s   = $signed(met_pkg::DELTA_W'({x_ff, 1'b0}));
      two_y_s   = $signed(met_pkg::DELTA_W'({y_ff, 1'b0}));
      width_s   = $signed(met_pkg::DELTA_W'(width_ff));
      height_s  = $signed(met_pkg::DELTA_W'(height_ff));
      dre       = two_x_s - width_s;
      dim       = height_s - two_y_s;
      step_s    = $signed({1'b0, step_ff});
      pre_re_in = dre * step_s;
      pre_im_in = dim * step_s;
      addr_full = y_ff * width_ff + met_pkg::ADDR_FULL_W'(x_ff);
      addr_in   = addr_full[met_pkg::ADDR_W-1:0];
   end

   // iteration: products of z are registered, escape test and update in the next cycle
   always_comb begin
      rr_in  = zre_ff * zre_ff;
      ii_in  = zim_ff * zim_ff;
      ri_in  = zre_ff * zim_ff;
      mag    = $unsigned(rr_ff) + $unsigned(ii_ff);
      diff   = rr_ff - ii_ff;
      shr_re = diff >>> met_pkg::Q_FRAC;
      shr_im = ri_ff >>> (met_pkg::Q_FRAC - 1);
      nre    = $signed(shr_re[met_pkg::SAT_W-1:0]) + met_pkg::SAT_W'(cre_ff);
      nim    = $signed(shr_im[met_pkg::SAT_W-1:0]) + met_pkg::SAT_W'(cim_ff);
      re_ext = met_pkg::SAT_W'(pre_re_ff);
      im_ext = met_pkg::SAT_W'(pre_im_ff);
   end

   always_comb begin
      x_in         = cmd.capture ? req_tdata[met_pkg::COORD_BITS-1:0] : x_ff;
      y_in         = cmd.capture ? req_tdata[2*met_pkg::COORD_BITS-1:met_pkg::COORD_BITS]
                                 : y_ff;
      cre_in       = cmd.init ? met_pkg::sat_q4(re_ext >>> 1) : cre_ff;
      cim_in       = cmd.init ? met_pkg::sat_q4(im_ext >>> 1) : cim_ff;
      zre_in       = zre_ff;
      zim_in       = zim_ff;
      count_in     = count_ff;
      if (cmd.init) begin
         zre_in   = '0;
         zim_in   = '0;
         count_in = '0;
      end else if (cmd.step) begin
         zre_in   = met_pkg::sat_q4(nre);
         zim_in   = met_pkg::sat_q4(nim);
         count_in = count_ff + 1'b1;
      end
      count_out_in = cmd.result ? count_ff : count_out_ff;
      addr_out_in  = cmd.result ? addr_ff : addr_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= met_pkg::WIDTH_RESET;
         height_ff <= met_pkg::HEIGHT_RESET;
         step_ff   <= met_pkg::STEP_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      if (cmd.point) begin
         pre_re_ff <= pre_re_in;
         pre_im_ff <= pre_im_in;
         addr_ff   <= addr_in;
      end
      if (cmd.square) begin
         rr_ff     <= rr_in;
         ii_ff     <= ii_in;
         ri_ff     <= ri_in;
      end
      cre_ff       <= cre_in;
      cim_ff       <= cim_in;
      zre_ff       <= zre_in;
      zim_ff       <= zim_in;
      count_ff     <= count_in;
      count_out_ff <= count_out_in;
      addr_out_ff  <= addr_out_in;
   end

   assign status.at_max  = (count_ff == met_pkg::MAX_ITERATIONS);
   assign status.escaped = (mag >= met_pkg::ESCAPE_LIMIT);
   assign rsp_tdata      = {addr_out_ff, count_out_ff};

endmodule

/* rtl/met_ctrl.sv */
// controller: sequences setup, iteration and result hand-off
`include "mandelbrot_escape_time_unit_assert.svh"

module met_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  met_pkg::status_type status,
   output met_pkg::cmd_type    cmd
);

   met_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign req_tready = (state_ff == met_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         met_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = met_pkg::S_LOAD;
            end
         end
         met_pkg::S_LOAD: begin
            cmd.point = 1'b1;
            state_in  = met_pkg::S_INIT;
         end
         met_pkg::S_INIT: begin
            cmd.init = 1'b1;
            state_in = met_pkg::S_MUL;
         end
         met_pkg::S_MUL: begin
            if (status.at_max) begin
               state_in = met_pkg::S_DONE;
            end else begin
               cmd.square = 1'b1;
               state_in   = met_pkg::S_UPD;
            end
         end
         met_pkg::S_UPD: begin
            if (status.escaped) begin
               state_in = met_pkg::S_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = met_pkg::S_MUL;
            end
         end
         met_pkg::S_DONE: begin
            // wait for the output register to drain
            if (out_free) begin
               cmd.result = 1'b1;
               state_in   = met_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = met_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= met_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MET_ASSERT_NEXT(a_accept_starts_setup, req_tvalid && req_tready, state_ff == met_pkg::S_LOAD, "accepted item did not start setup")
   `MET_ASSERT_NOW(a_result_into_free_reg, cmd.result, !rsp_valid_ff || rsp_tready, "result overwrote a pending item")
   `MET_ASSERT_NOW(a_update_follows_square, state_ff == met_pkg::S_UPD, $past(state_ff) == met_pkg::S_MUL, "update without fresh products")
   `MET_ASSERT_NEXT(a_limit_ends_iteration, (state_ff == met_pkg::S_MUL) && status.at_max, state_ff == met_pkg::S_DONE, "iteration ran past the limit")

endmodule

/* rtl/mandelbrot_escape_time_unit.sv */
// top level of the mandelbrot escape time unit
//
//   channel  direction  payload (low bit first)
//   req_     in         pixel_x[11:0], pixel_y[23:12]
//   rsp_     out        escape_count[7:0], buffer_address[31:8]
//   csr_     in         index 0 image_width, 1 image_height, 2 pixel_step
//
// one pixel at a time: accept, setup in S_LOAD and S_INIT, then each iteration
// (three 32x32 products of z registered in S_MUL, escape test and z update in S_UPD)
// runs on the shared square-and-add unit until the pixel escapes or the count
// reaches the iteration limit
// the result sits in an output register, so req_tready returns while it waits
// synchronous active-high reset restores the image size and step defaults
module mandelbrot_escape_time_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [met_pkg::REQ_DATA_W-1:0]   req_tdata,   // pixel_x, pixel_y
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [met_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // escape_count, buffer_address
   input  logic                             csr_wr_en,
   input  logic [met_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [met_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   met_pkg::cmd_type    cmd;
   met_pkg::status_type status;

   met_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   met_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* tb/tb_mandelbrot_escape_time_unit.sv */
`timescale 1ns / 100ps
// self-checking testbench of the mandelbrot escape time unit: directed table, then random phases
module tb_mandelbrot_escape_time_unit;

   localparam int QUIET_LIMIT = 4000;
   localparam int ERR_SHOWN   = 10;
   localparam int PHASES      = 16;
   localparam int PHASE_ITEMS = 124;
   localparam int TAIL_CYCLES = 520;

   localparam longint          Q_HI         = 64'sd2147483647;
   localparam longint          Q_LO         = -64'sd2147483648;
   localparam longint unsigned ESCAPE_BOUND = 64'd4 << 56;

   localparam logic PIX = 1'b0;
   localparam logic WR  = 1'b1;

   typedef struct packed {
      logic [met_pkg::ADDR_W-1:0]  buffer_address;
      logic [met_pkg::COUNT_W-1:0] escape_count;
   } pixel_result_type;

   typedef struct packed {
      logic                            is_write;
      logic [met_pkg::CSR_INDEX_W-1:0] reg_sel;
      logic [met_pkg::CSR_DATA_W-1:0]  value;
      logic [met_pkg::COORD_BITS-1:0]  px;
      logic [met_pkg::COORD_BITS-1:0]  py;
      logic                            pinned;
      pixel_result_type                want;
   } stim_row_type;

   // register fields are unused on pixel rows, pinned results are typed in where obvious
   localparam stim_row_type DIRECTED [27] = '{
      '{PIX, '0, '0, 12'd0,    12'd0,    1'b1, '{24'd0,       8'd1}},
      '{PIX, '0, '0, 12'd4095, 12'd4095, 1'b1, '{24'd2100735, 8'd1}},
      '{PIX, '0, '0, 12'd256,  12'd256,  1'b1, '{24'd131328,  8'd255}},
      '{PIX, '0, '0, 12'd4095, 12'd0,    1'b0, '0},
      '{PIX, '0, '0, 12'd0,    12'd4095, 1'b0, '0},
      '{PIX, '0, '0, 12'd511,  12'd0,    1'b0, '0},
      '{PIX, '0, '0, 12'd0,    12'd511,  1'b0, '0},
      '{PIX, '0, '0, 12'hAAA,  12'h555,  1'b0, '0},
      '{PIX, '0, '0, 12'h555,  12'hAAA,  1'b0, '0},
      '{PIX, '0, '0, 12'd100,  12'd180,  1'b0, '0},
      '{PIX, '0, '0, 12'd383,  12'd256,  1'b0, '0},
      // one pixel image, largest step: c saturates for pixels outside the image
      '{WR, met_pkg::CSR_IMAGE_WIDTH,  31'd1,         '0, '0, 1'b0, '0},
      '{WR, met_pkg::CSR_IMAGE_HEIGHT, 31'd1,         '0, '0, 1'b0, '0},
      '{WR, met_pkg::CSR_PIXEL_STEP,   31'h7FFF_FFFF, '0, '0, 1'b0, '0},
      '{PIX, '0, '0, 12'd0,    12'd0,    1'b1, '{24'd0,       8'd1}},
      '{PIX, '0, '0, 12'd4095, 12'd4095, 1'b1, '{24'd8190,    8'd1}},
      // zero sized image, zero step: c is the origin
      '{WR, met_pkg::CSR_IMAGE_WIDTH,  31'd0,         '0, '0, 1'b0, '0},
      '{WR, met_pkg::CSR_IMAGE_HEIGHT, 31'd0,         '0, '0, 1'b0, '0},
      '{WR, met_pkg::CSR_PIXEL_STEP,   31'd0,         '0, '0, 1'b0, '0},
      '{PIX, '0, '0, 12'd4095, 12'd4095, 1'b1, '{24'd4095,    8'd255}},
      '{PIX, '0, '0, 12'd0,    12'd0,    1'b1, '{24'd0,       8'd255}},
      // widest image: address wraps
      '{WR, met_pkg::CSR_IMAGE_WIDTH,  31'd8191,      '0, '0, 1'b0, '0},
      '{WR, met_pkg::CSR_IMAGE_HEIGHT, 31'd8191,      '0, '0, 1'b0, '0},
      '{WR, met_pkg::CSR_PIXEL_STEP,   31'd2097152,   '0, '0, 1'b0, '0},
      '{PIX, '0, '0, 12'd4095, 12'd4095, 1'b1, '{24'd16769024, 8'd255}},
      '{PIX, '0, '0, 12'd0,    12'd0,    1'b1, '{24'd0,       8'd1}},
      '{PIX, '0, '0, 12'd4095, 12'd4093, 1'b0, '0}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [met_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [met_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            csr_wr_en = 1'b0;
   logic [met_pkg::CSR_INDEX_W-1:0] csr_index = met_pkg::CSR_IMAGE_WIDTH;
   logic [met_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of the registers
   logic [met_pkg::DIM_W-1:0]  cfg_width  = 13'd512;
   logic [met_pkg::DIM_W-1:0]  cfg_height = 13'd512;
   logic [met_pkg::STEP_W-1:0] cfg_step   = 31'd2097152;

   pixel_result_type escape_q [$];
   pixel_result_type pin_want = '0;
   pixel_result_type got, want;
   logic             pin_valid = 1'b0;
   logic             gaps_on = 1'b0;
   int               stall_left = 0;
   int               errors = 0;
   int               quiet_cycles = 0;

   mandelbrot_escape_time_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_q4(input longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
   endfunction

   // escape count of one pixel and its row-major address
   function automatic pixel_result_type escape_of(input logic [met_pkg::COORD_BITS-1:0] x, y);
      longint           step, cre, cim, zre, zim, rr, ii, ri;
      longint unsigned  mag, addr;
      int unsigned      n;
      bit               gone;
      pixel_result_type r;
      step = longint'(cfg_step);
      cre  = clamp_q4(((2 * longint'(x) - longint'(cfg_width)) * step) >>> 1);
      cim  = clamp_q4(((longint'(cfg_height) - 2 * longint'(y)) * step) >>> 1);
      zre  = 0;
      zim  = 0;
      n    = 0;
      gone = 1'b0;
      while (n < met_pkg::MAX_ITERATIONS && !gone) begin
         rr  = zre * zre;
         ii  = zim * zim;
         mag = unsigned'(rr) + unsigned'(ii);
         if (mag >= ESCAPE_BOUND) begin
            gone = 1'b1;
         end else begin
            ri  = zre * zim;
            zre = clamp_q4(((rr - ii) >>> met_pkg::Q_FRAC) + cre);
            zim = clamp_q4((ri >>> (met_pkg::Q_FRAC - 1)) + cim);
            n++;
         end
      end
      addr = longint'(y) * longint'(cfg_width) + longint'(x);
      r.escape_count   = n[met_pkg::COUNT_W-1:0];
      r.buffer_address = addr[met_pkg::ADDR_W-1:0];
      return r;
   endfunction

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = int'($urandom_range(0, 5));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg_width  = met_pkg::WIDTH_RESET;
         cfg_height = met_pkg::HEIGHT_RESET;
         cfg_step   = met_pkg::STEP_RESET;
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            escape_q.push_back(pin_valid ? pin_want :
                  escape_of(req_tdata[met_pkg::COORD_BITS-1:0],
                            req_tdata[2*met_pkg::COORD_BITS-1:met_pkg::COORD_BITS]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (escape_q.size() == 0) begin
               errors++;
               if (errors <= ERR_SHOWN)
                  $display("unexpected result: escape_count %0d buffer_address %0d",
                           got.escape_count, got.buffer_address);
            end else begin
               want = escape_q.pop_front();
               if (got.escape_count != want.escape_count ||
                   got.buffer_address != want.buffer_address) begin
                  errors++;
                  if (errors <= ERR_SHOWN)
                     $display({"mismatch: escape_count exp %0d got %0d, ",
                               "buffer_address exp %0d got %0d"},
                              want.escape_count, got.escape_count,
                              want.buffer_address, got.buffer_address);
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               met_pkg::CSR_IMAGE_WIDTH:  cfg_width  = csr_wdata[met_pkg::DIM_W-1:0];
               met_pkg::CSR_IMAGE_HEIGHT: cfg_height = csr_wdata[met_pkg::DIM_W-1:0];
               met_pkg::CSR_PIXEL_STEP:   cfg_step   = csr_wdata[met_pkg::STEP_W-1:0];
               default: ;
            endcase
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("mandelbrot_escape_time_unit regression: fail");
         $finish;
      end
   end

   // called and returning at a falling edge
   task automatic send_pixel(input logic [met_pkg::COORD_BITS-1:0] x, y, input logic pinned,
                             input pixel_result_type want_in);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      pin_valid  <= pinned;
      pin_want   <= want_in;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [met_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [met_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (escape_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      int                             ph, k, n_items;
      int unsigned                    span, scale;
      logic [met_pkg::DIM_W-1:0]      w, h;
      logic [met_pkg::STEP_W-1:0]     step;
      logic [met_pkg::COORD_BITS-1:0] x, y;
      stim_row_type                   row;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      gaps_on <= 1'b1;

      for (k = 0; k < $size(DIRECTED); k++) begin
         row = DIRECTED[k];
         if (row.is_write) begin
            if (k > 0 && !DIRECTED[k-1].is_write) drain();
            write_reg(row.reg_sel, row.value);
         end else begin
            send_pixel(row.px, row.py, row.pinned, row.want);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         gaps_on <= (ph < PHASES - 3) && (ph % 4 != 3);
         // grid of 2 to 5 units over the smaller side
         scale = $urandom_range(32'h2000_0000, 32'h5000_0000);
         w = met_pkg::DIM_W'($urandom_range(0, 1) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 4096));
         h = met_pkg::DIM_W'($urandom_range(0, 1) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 4096));
         case (ph)
            0: begin w = 13'd512;  h = 13'd512;  end
            1: begin w = 13'd4096; h = 13'd4096; end
            2: begin w = 13'd1;    h = 13'd4096; end
            3: begin w = 13'd4096; h = 13'd1;    end
            6: begin w = 13'd8191; h = 13'd8191; end
            7: w = 13'd0;
            8: h = 13'd0;
            default: ;
         endcase
         span = 32'((w < h) ? w : h);
         step = met_pkg::STEP_W'((span == 0) ? scale : scale / span);
         if (ph == 0) step = 31'd2097152;
         if (ph == 4) step = 31'h7FFF_FFFF;
         if (ph == 5) step = 31'd0;
         write_reg(met_pkg::CSR_IMAGE_WIDTH, met_pkg::CSR_DATA_W'(w));
         write_reg(met_pkg::CSR_IMAGE_HEIGHT, met_pkg::CSR_DATA_W'(h));
         write_reg(met_pkg::CSR_PIXEL_STEP, step);
         // a zero step keeps every pixel at the origin, the slowest case
         n_items = (step == 0) ? 20 : PHASE_ITEMS;
         for (k = 0; k < n_items; k++) begin
            x = met_pkg::COORD_BITS'((w == 0 || $urandom_range(0, 6) == 0)
                   ? $urandom_range(0, 4095)
                   : $urandom_range(0, ((w > 4096) ? 4096 : w) - 1));
            y = met_pkg::COORD_BITS'((h == 0 || $urandom_range(0, 6) == 0)
                   ? $urandom_range(0, 4095)
                   : $urandom_range(0, ((h > 4096) ? 4096 : h) - 1));
            send_pixel(x, y, 1'b0, '0);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0 && escape_q.size() == 0)
         $display("mandelbrot_escape_time_unit regression: pass");
      else
         $display("mandelbrot_escape_time_unit regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/met_pkg.sv
rtl/met_datapath.sv
rtl/met_ctrl.sv
rtl/mandelbrot_escape_time_unit.sv
tb/tb_mandelbrot_escape_time_unit.sv
